/* src/pgm_pkg.sv */
// ----------------------------------------------------------------------------
// pgm_pkg
// Shared types, register codes and helpers for the poly22 gain schedule block.
// ----------------------------------------------------------------------------
package pgm_pkg;

    // fit terms per gain entry: p00, p10, p01, p20, p11, p02
    localparam int TERMS        = 6;
    localparam int FRAC_BITS    = 16;
    localparam int DEF_MAX_ROWS = 4;
    localparam int DEF_MAX_COLS = 16;

    // configuration register indexes
    localparam logic [1:0] REG_MIN_INPUT   = 2'd0;
    localparam logic [1:0] REG_MAX_INPUT   = 2'd1;
    localparam logic [1:0] REG_OUTPUT_ROWS = 2'd2;
    localparam logic [1:0] REG_STATE_COLS  = 2'd3;

    // input opcodes
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_EVAL  = 1'b1;

    typedef struct packed {
        logic               opcode;
        logic [8:0]         coef_index;
        logic signed [31:0] coef_value;
        logic signed [31:0] x_in;
        logic signed [31:0] y_in;
    } in_beat_t;

    typedef struct packed {
        logic [1:0]         row_index;
        logic [3:0]         col_index;
        logic signed [31:0] gain;
        logic signed [31:0] clamped_x;
        logic signed [31:0] clamped_y;
        logic               was_clamped;
        logic               last;
    } out_beat_t;

    // per-entry context handed from the sequencer to the evaluation pipe
    typedef struct packed {
        logic [1:0]         row_index;
        logic [3:0]         col_index;
        logic               last;
        logic signed [31:0] clamped_x;
        logic signed [31:0] clamped_y;
        logic               was_clamped;
        logic signed [31:0] mxx;
        logic signed [31:0] mxy;
        logic signed [31:0] myy;
    } issue_t;

    // saturate a 64-bit value to signed 32 bits
    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v[63:31] == {33{1'b0}} || v[63:31] == {33{1'b1}})
            r = v[31:0];
        else if (v[63])
            r = 32'sh8000_0000;
        else
            r = 32'sh7FFF_FFFF;
        return r;
    endfunction

endpackage

/* src/poly22_gain_matrix_schedule.sv */
// ----------------------------------------------------------------------------
// poly22_gain_matrix_schedule
// Gain matrix evaluator over a store of bivariate quadratic fits.
// ----------------------------------------------------------------------------
// Usage:
//   in channel (in_valid/in_ready/in_beat): a write beat (opcode 0) stores one
//   coefficient at coef_index = entry*6 + term, addresses past the store are
//   dropped. An evaluate beat (opcode 1) clamps x_in and y_in to the
//   configured range and produces rows*cols result beats in row-major order.
//   out channel (out_valid/out_ready/out_beat): one beat per gain entry, the
//   final one flagged by last.
//   cfg port: cfg_we/cfg_addr/cfg_wdata; the user must write it only while
//   idle, since the block itself does not enforce this.
// Sequencing:
//   a write beat leaves the input ready for the next beat. An evaluate beat
//   steps through clamp, square/cross products and monomial setup, then issues
//   one entry per cycle, unless an output stall holds it, into a five-stage
//   read/multiply/sum pipeline. The next beat is accepted once the last entry
//   has been issued.
// Reset: control and configuration registers go to their defaults; the
//   coefficient store holds garbage until written.
// Stall: a low out_ready with out_valid high freezes the whole pipeline and
//   the issue sequencer; nothing is dropped or repeated.
// ----------------------------------------------------------------------------
module poly22_gain_matrix_schedule
    import pgm_pkg::*;
#(
    parameter int MAX_ROWS = DEF_MAX_ROWS,
    parameter int MAX_COLS = DEF_MAX_COLS
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_addr,
    input  logic [31:0] cfg_wdata,
    input  logic        in_valid,
    output logic        in_ready,
    input  in_beat_t    in_beat,
    output logic        out_valid,
    input  logic        out_ready,
    output out_beat_t   out_beat
);

    localparam int ENTRIES = MAX_ROWS * MAX_COLS;
    localparam int AW      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int RW      = $clog2(MAX_ROWS + 1);
    localparam int CW      = $clog2(MAX_COLS + 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLAMP,
        ST_MULT,
        ST_MONO,
        ST_ISSUE
    } state_t;

    state_t             state_reg;
    logic signed [31:0] min_reg, max_reg;
    logic [2:0]         rows_cfg_reg;
    logic [4:0]         cols_cfg_reg;
    logic [RW-1:0]      rows_reg, row_reg;
    logic [CW-1:0]      cols_reg, col_reg;
    logic [AW-1:0]      addr_reg;
    logic signed [31:0] x_reg, y_reg, cx_reg, cy_reg;
    logic               flag_reg;
    logic signed [63:0] pxx_reg, pxy_reg, pyy_reg;
    logic signed [31:0] mxx_reg, mxy_reg, myy_reg;

    logic               accept;
    logic               advance;
    logic               iss_valid;
    logic               last_entry;
    issue_t             iss_info;
    logic [19:0]        div_prod;
    logic [7:0]         wr_ent;
    logic [8:0]         wr_base;
    logic [2:0]         wr_term;
    logic               wr_en;
    logic signed [31:0] cx_next, cy_next;
    logic [RW-1:0]      rows_sat;
    logic [CW-1:0]      cols_sat;

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_reg      <= 32'sd0;
            max_reg      <= 32'sd65536;
            rows_cfg_reg <= 3'd2;
            cols_cfg_reg <= 5'd6;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_MIN_INPUT:   min_reg      <= cfg_wdata;
                REG_MAX_INPUT:   max_reg      <= cfg_wdata;
                REG_OUTPUT_ROWS: rows_cfg_reg <= cfg_wdata[2:0];
                REG_STATE_COLS:  cols_cfg_reg <= cfg_wdata[4:0];
                default: ;
            endcase
        end
    end

    // coefficient address split: entry = index / 6 by reciprocal multiply
    assign div_prod = 20'(in_beat.coef_index) * 20'd683;
    assign wr_ent   = div_prod[19:12];
    assign wr_base  = 9'(wr_ent) * 9'd6;
    assign wr_term  = 3'(in_beat.coef_index - wr_base);
    assign wr_en    = accept && (in_beat.opcode == OP_WRITE) && (int'(wr_ent) < ENTRIES);

    // clamp against the configured bounds
    assign cx_next = (x_reg < min_reg) ? min_reg : ((x_reg > max_reg) ? max_reg : x_reg);
    assign cy_next = (y_reg < min_reg) ? min_reg : ((y_reg > max_reg) ? max_reg : y_reg);

    // matrix size limited to the store shape
    assign rows_sat = (int'(rows_cfg_reg) > MAX_ROWS) ? RW'(MAX_ROWS) : RW'(rows_cfg_reg);
    assign cols_sat = (int'(cols_cfg_reg) > MAX_COLS) ? CW'(MAX_COLS) : CW'(cols_cfg_reg);

    // issue context
    assign iss_valid  = (state_reg == ST_ISSUE);
    assign last_entry = (row_reg == rows_reg - RW'(1)) && (col_reg == cols_reg - CW'(1));

    always_comb
    begin
        iss_info.row_index   = 2'(row_reg);
        iss_info.col_index   = 4'(col_reg);
        iss_info.last        = last_entry;
        iss_info.clamped_x   = cx_reg;
        iss_info.clamped_y   = cy_reg;
        iss_info.was_clamped = flag_reg;
        iss_info.mxx         = mxx_reg;
        iss_info.mxy         = mxy_reg;
        iss_info.myy         = myy_reg;
    end

    // sequencer: setup steps then one entry per advancing cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            rows_reg  <= '0;
            cols_reg  <= '0;
            row_reg   <= '0;
            col_reg   <= '0;
            addr_reg  <= '0;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    if (accept && in_beat.opcode == OP_EVAL)
                    begin
                        rows_reg  <= rows_sat;
                        cols_reg  <= cols_sat;
                        state_reg <= ST_CLAMP;
                    end
                end
                ST_CLAMP:
                    state_reg <= ST_MULT;
                ST_MULT:
                    state_reg <= ST_MONO;
                ST_MONO:
                begin
                    row_reg  <= '0;
                    col_reg  <= '0;
                    addr_reg <= '0;
                    if (rows_reg == '0 || cols_reg == '0)
                        state_reg <= ST_IDLE;
                    else
                        state_reg <= ST_ISSUE;
                end
                ST_ISSUE:
                begin
                    if (advance)
                    begin
                        addr_reg <= addr_reg + AW'(1);
                        if (last_entry)
                            state_reg <= ST_IDLE;
                        else if (col_reg == cols_reg - CW'(1))
                        begin
                            col_reg <= '0;
                            row_reg <= row_reg + RW'(1);
                        end
                        else
                            col_reg <= col_reg + CW'(1);
                    end
                end
                default:
                    state_reg <= ST_IDLE;
            endcase
        end
    end

    // per-item datapath: capture, clamp, square/cross products, monomials
    always_ff @(posedge clk)
    begin
        if (accept && in_beat.opcode == OP_EVAL)
        begin
            x_reg <= in_beat.x_in;
            y_reg <= in_beat.y_in;
        end
        if (state_reg == ST_CLAMP)
        begin
            cx_reg   <= cx_next;
            cy_reg   <= cy_next;
            flag_reg <= (cx_next != x_reg) || (cy_next != y_reg);
        end
        if (state_reg == ST_MULT)
        begin
            pxx_reg <= cx_reg * cx_reg;
            pxy_reg <= cx_reg * cy_reg;
            pyy_reg <= cy_reg * cy_reg;
        end
        if (state_reg == ST_MONO)
        begin
            mxx_reg <= sat32(pxx_reg >>> FRAC_BITS);
            mxy_reg <= sat32(pxy_reg >>> FRAC_BITS);
            myy_reg <= sat32(pyy_reg >>> FRAC_BITS);
        end
    end

    // evaluation pipeline
    pgm_eval_pipe #(
        .ENTRIES (ENTRIES),
        .AW      (AW)
    ) u_pipe (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_en     (wr_en),
        .wr_term   (wr_term),
        .wr_addr   (AW'(wr_ent)),
        .wr_data   (in_beat.coef_value),
        .iss_valid (iss_valid),
        .iss_addr  (addr_reg),
        .iss_info  (iss_info),
        .advance   (advance),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_beat  (out_beat)
    );

    // a stalled output freezes the issue address
    a_stall_holds_issue: assert property (@(posedge clk) disable iff (!rst_n)
        (iss_valid && out_valid && !out_ready) |=> $stable(addr_reg))
        else $error("issue address moved during output stall");

    // the last entry is issued at the end of the row-major sweep
    a_last_at_end: assert property (@(posedge clk) disable iff (!rst_n)
        (iss_valid && last_entry) |->
            (int'(addr_reg) == int'(rows_reg) * int'(cols_reg) - 1))
        else $error("last entry flagged at wrong address");

    // an evaluate beat starts the setup sequence
    a_eval_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && in_beat.opcode == OP_EVAL) |=> (state_reg == ST_CLAMP))
        else $error("evaluate beat did not start setup");

    // no entry issued while the input side is open
    a_no_issue_when_ready: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> !iss_valid)
        else $error("entry issued while accepting input");

endmodule

/* src/pgm_eval_pipe.sv */
// ----------------------------------------------------------------------------
// pgm_eval_pipe
// Coefficient banks and the per-entry evaluation pipeline: read, multiply,
// partial sums, final sum, saturate into the output register.
// ----------------------------------------------------------------------------
module pgm_eval_pipe
    import pgm_pkg::*;
#(
    parameter int ENTRIES = DEF_MAX_ROWS * DEF_MAX_COLS,
    parameter int AW      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr_en,
    input  logic [2:0]    wr_term,
    input  logic [AW-1:0] wr_addr,
    input  logic [31:0]   wr_data,
    input  logic          iss_valid,
    input  logic [AW-1:0] iss_addr,
    input  issue_t        iss_info,
    output logic          advance,
    output logic          out_valid,
    input  logic          out_ready,
    output out_beat_t     out_beat
);

    // one bank per fit term, all read at the same entry address
    logic [31:0] mem [TERMS][ENTRIES];

    logic               s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg;
    logic               out_valid_reg;
    issue_t             s1_info_reg, s2_info_reg, s3_info_reg, s4_info_reg;
    logic signed [31:0] coef_reg [TERMS];
    logic signed [63:0] p00_reg;
    logic signed [63:0] prod_reg [1:5];
    logic signed [63:0] sum_a_reg, sum_b_reg, sum_c_reg;
    logic signed [63:0] sum_reg;
    out_beat_t          out_reg;

    assign advance   = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign out_beat  = out_reg;

    // coefficient write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_term][wr_addr] <= wr_data;
    end

    // registered read of all six terms
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            for (int k = 0; k < TERMS; k++)
                coef_reg[k] <= mem[k][iss_addr];
        end
    end

    // valid bits travel with the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            s4_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg  <= iss_valid;
            s2_valid_reg  <= s1_valid_reg;
            s3_valid_reg  <= s2_valid_reg;
            s4_valid_reg  <= s3_valid_reg;
            out_valid_reg <= s4_valid_reg;
        end
    end

    // datapath stages
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_info_reg <= iss_info;

            // products of coefficients and monomials
            s2_info_reg <= s1_info_reg;
            p00_reg     <= 64'(coef_reg[0]);
            prod_reg[1] <= coef_reg[1] * s1_info_reg.clamped_x;
            prod_reg[2] <= coef_reg[2] * s1_info_reg.clamped_y;
            prod_reg[3] <= coef_reg[3] * s1_info_reg.mxx;
            prod_reg[4] <= coef_reg[4] * s1_info_reg.mxy;
            prod_reg[5] <= coef_reg[5] * s1_info_reg.myy;

            // truncate terms and form pair sums
            s3_info_reg <= s2_info_reg;
            sum_a_reg   <= p00_reg + (prod_reg[1] >>> FRAC_BITS);
            sum_b_reg   <= (prod_reg[2] >>> FRAC_BITS) + (prod_reg[3] >>> FRAC_BITS);
            sum_c_reg   <= (prod_reg[4] >>> FRAC_BITS) + (prod_reg[5] >>> FRAC_BITS);

            // final sum
            s4_info_reg <= s3_info_reg;
            sum_reg     <= sum_a_reg + sum_b_reg + sum_c_reg;

            // saturate into the output register
            out_reg.row_index   <= s4_info_reg.row_index;
            out_reg.col_index   <= s4_info_reg.col_index;
            out_reg.gain        <= sat32(sum_reg);
            out_reg.clamped_x   <= s4_info_reg.clamped_x;
            out_reg.clamped_y   <= s4_info_reg.clamped_y;
            out_reg.was_clamped <= s4_info_reg.was_clamped;
            out_reg.last        <= s4_info_reg.last;
        end
    end

endmodule
